// ----- hw/rtl/cpbm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpbm_pkg
// shared types and constants of the contiguous page bitmap allocator
// ----------------------------------------------------------------------------
package cpbm_pkg;

  localparam int MAP_WORDS_DEF  = 32;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam int WORD_BITS  = 32;
  localparam int BIT_IDX_W  = 5;
  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 11;
  localparam int FIRST_W    = 10;
  // run length width: a run never exceeds the count by more than one word
  localparam int RUN_W      = 12;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [COUNT_W-1:0] page_count;
    logic [ADDR_W-1:0]  free_address;
  } req_t;

  typedef struct packed {
    logic               success;
    logic [ADDR_W-1:0]  run_address;
    logic [FIRST_W-1:0] first_page;
  } rsp_t;

  // result of searching one map word for the end of a free run
  typedef struct packed {
    logic                 hit;
    logic [BIT_IDX_W-1:0] pos;
    logic [RUN_W-1:0]     run_out;
  } find_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cpbm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpbm_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module cpbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cpbm_run_finder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpbm_run_finder
// finds the lowest bit of one map word at which a free run reaches the count
// ----------------------------------------------------------------------------
module cpbm_run_finder (
  input  wire logic [cpbm_pkg::WORD_BITS-1:0] word,
  input  wire logic [cpbm_pkg::RUN_W-1:0]     run_in,
  input  wire logic [cpbm_pkg::COUNT_W-1:0]   count,
  output cpbm_pkg::find_t                     find
);

  localparam int NB = cpbm_pkg::WORD_BITS;
  localparam int LV = cpbm_pkg::BIT_IDX_W;

  // prefix tree: highest used bit at or below each position
  logic                              lu_v [LV+1][NB];
  logic [cpbm_pkg::BIT_IDX_W-1:0]    lu_i [LV+1][NB];
  logic [cpbm_pkg::RUN_W-1:0]        run_end [NB];
  logic [NB-1:0]                     hit;

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      lu_v[0][b] = word[b];
      lu_i[0][b] = cpbm_pkg::BIT_IDX_W'(b);
    end
    for (int d = 0; d < LV; d++) begin
      for (int b = 0; b < NB; b++) begin
        if (lu_v[d][b] || b < (1 << d)) begin
          lu_v[d+1][b] = lu_v[d][b];
          lu_i[d+1][b] = lu_i[d][b];
        end else begin
          lu_v[d+1][b] = lu_v[d][b - (1 << d)];
          lu_i[d+1][b] = lu_i[d][b - (1 << d)];
        end
      end
    end
    for (int b = 0; b < NB; b++) begin
      if (lu_v[LV][b]) begin
        run_end[b] = cpbm_pkg::RUN_W'(b) - cpbm_pkg::RUN_W'(lu_i[LV][b]);
      end else begin
        run_end[b] = run_in + cpbm_pkg::RUN_W'(b) + cpbm_pkg::RUN_W'(1);
      end
      hit[b] = !word[b] && (run_end[b] >= cpbm_pkg::RUN_W'(count));
    end
    find.hit     = |hit;
    find.pos     = '0;
    for (int b = NB - 1; b >= 0; b--) begin
      if (hit[b]) begin
        find.pos = cpbm_pkg::BIT_IDX_W'(b);
      end
    end
    find.run_out = run_end[NB-1];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/contiguous_page_bitmap_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator
// first-fit allocator of contiguous page runs over a usage bitmap in ram
// ----------------------------------------------------------------------------
// req channel (req_valid / req_stall / req) takes one item at a time: an
// allocate of page_count pages, or a free of page_count pages at free_address.
// rsp channel (rsp_valid / rsp_stall / rsp) returns one item per request:
// success, the run address and the first page (both zero on free or failure).
// cfg channel (cfg_valid / cfg_ready / cfg_data) writes region_base; it is
// always ready and is to be written only while no request is in flight.
// the single map ram reads one word and writes one word per cycle: allocate
// scans the words up to the hit, then marks the words of the run; free
// clears the words of the run. a failing allocate scans every map word, and
// an allocate of zero pages goes straight to its result. after reset the map
// is cleared one word a cycle with req_stall high; configuration writes are
// taken during that pass.
// the result sits in an output register; the next request is taken while it
// waits, but that request's result waits for the receiver to drop rsp_stall.
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator #(
  parameter int MAP_WORDS  = cpbm_pkg::MAP_WORDS_DEF,
  parameter int PAGE_BYTES = cpbm_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire cpbm_pkg::req_t              req,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output cpbm_pkg::rsp_t                   rsp,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [cpbm_pkg::ADDR_W-1:0] cfg_data
);

  // word index and page index widths
  localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW = WW + cpbm_pkg::BIT_IDX_W;
  localparam int SH = $clog2(PAGE_BYTES);
  localparam int XW = cpbm_pkg::ADDR_W + 1;
  localparam logic [XW-1:0] TOTAL = XW'(MAP_WORDS * cpbm_pkg::WORD_BITS);
  localparam logic [WW-1:0] LAST_W = WW'(MAP_WORDS - 1);
  localparam logic [cpbm_pkg::WORD_BITS-1:0] ONES = '1;

  typedef enum logic [7:0] {
    S_CLEAR     = 8'b0000_0001,
    S_IDLE      = 8'b0000_0010,
    S_FREE_PREP = 8'b0000_0100,
    S_SCAN      = 8'b0000_1000,
    S_PLACE     = 8'b0001_0000,
    S_RANGE     = 8'b0010_0000,
    S_RMW       = 8'b0100_0000,
    S_DONE      = 8'b1000_0000
  } state_t;

  state_t                          state;
  logic [cpbm_pkg::ADDR_W-1:0]     region_base;

  // request held for the whole operation
  logic                            op;
  logic [cpbm_pkg::COUNT_W-1:0]    count;
  logic [cpbm_pkg::ADDR_W-1:0]     free_addr;
  logic [cpbm_pkg::ADDR_W-1:0]     start;

  // word range touched by the read-modify-write pass
  logic [PW-1:0]                   lo;
  logic [PW-1:0]                   hi;

  // ram read pipeline: issue index, returning index, pending flag
  logic [WW-1:0]                   iw;
  logic                            iss_on;
  logic [WW-1:0]                   dw;
  logic                            pend;
  logic [WW-1:0]                   clr_w;

  logic [cpbm_pkg::RUN_W-1:0]      run_in;
  logic [WW-1:0]                   hit_w;
  logic [cpbm_pkg::BIT_IDX_W-1:0]  hit_b;

  cpbm_pkg::rsp_t                  res;

  logic                            mem_we;
  logic [WW-1:0]                   mem_waddr;
  logic [cpbm_pkg::WORD_BITS-1:0]  mem_wdata;
  logic [cpbm_pkg::WORD_BITS-1:0]  mem_rdata;
  cpbm_pkg::find_t                 find;

  // range and mask helpers
  logic [XW-1:0]                   end_excl;
  logic [XW-1:0]                   last_pg;
  logic [XW-1:0]                   first_x;
  logic [cpbm_pkg::BIT_IDX_W-1:0]  lo_b;
  logic [cpbm_pkg::BIT_IDX_W-1:0]  hi_b;
  logic [cpbm_pkg::WORD_BITS-1:0]  mask;
  logic                            req_take;
  logic                            rsp_free;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign cfg_ready = 1'b1;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  cpbm_ram #(
    .WIDTH (cpbm_pkg::WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (iw),
    .rdata (mem_rdata)
  );

  cpbm_run_finder u_find (
    .word   (mem_rdata),
    .run_in (run_in),
    .count  (count),
    .find   (find)
  );

  always_comb begin
    end_excl = XW'(start) + XW'(count);
    last_pg  = end_excl - XW'(1);
    first_x  = XW'({hit_w, hit_b}) + XW'(1) - XW'(count);
    // bits of the returning word that fall inside the run
    lo_b = (dw == lo[PW-1:cpbm_pkg::BIT_IDX_W]) ? lo[cpbm_pkg::BIT_IDX_W-1:0] : '0;
    hi_b = (dw == hi[PW-1:cpbm_pkg::BIT_IDX_W]) ? hi[cpbm_pkg::BIT_IDX_W-1:0] : '1;
    mask = (ONES << lo_b) & (ONES >> (~hi_b));
    mem_we    = 1'b0;
    mem_waddr = dw;
    mem_wdata = (op == cpbm_pkg::OP_FREE) ? (mem_rdata & ~mask) : (mem_rdata | mask);
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_w;
        mem_wdata = '0;
      end
      S_RMW: begin
        mem_we = pend;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      region_base <= cfg_data;
    end
  end

  // output register, refilled only once the held item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      rsp <= res;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      clr_w  <= '0;
      iss_on <= 1'b0;
      pend   <= 1'b0;
    end else begin
      // read pipeline advances by default
      pend <= iss_on;
      dw   <= iw;
      case (state)
        S_CLEAR: begin
          if (clr_w == LAST_W) begin
            state <= S_IDLE;
          end else begin
            clr_w <= clr_w + WW'(1);
          end
        end
        S_IDLE: begin
          if (req_take) begin
            op        <= req.operation;
            count     <= req.page_count;
            free_addr <= req.free_address;
            // empty allocate fails at once, everything else starts as a success
            res       <= '{success: (req.operation == cpbm_pkg::OP_FREE) ||
                                    (req.page_count != '0),
                           run_address: '0, first_page: '0};
            if (req.operation == cpbm_pkg::OP_FREE) begin
              state <= S_FREE_PREP;
            end else if (req.page_count == '0) begin
              state <= S_DONE;
            end else begin
              iw     <= '0;
              iss_on <= 1'b1;
              run_in <= '0;
              state  <= S_SCAN;
            end
          end
        end
        S_FREE_PREP: begin
          start <= (free_addr - region_base) >> SH;
          state <= S_RANGE;
        end
        S_SCAN: begin
          if (pend && find.hit) begin
            hit_w  <= dw;
            hit_b  <= find.pos;
            iss_on <= 1'b0;
            state  <= S_PLACE;
          end else begin
            if (iss_on) begin
              if (iw == LAST_W) begin
                iss_on <= 1'b0;
              end else begin
                iw <= iw + WW'(1);
              end
            end
            if (pend) begin
              // issue has already stopped once the last word returns
              if (dw == LAST_W) begin
                res.success <= 1'b0;
                state       <= S_DONE;
              end else begin
                run_in <= find.run_out;
              end
            end
          end
        end
        S_PLACE: begin
          start <= first_x[cpbm_pkg::ADDR_W-1:0];
          res   <= '{success: 1'b1,
                     run_address: region_base +
                                  (cpbm_pkg::ADDR_W'(first_x[PW-1:0]) << SH),
                     first_page: cpbm_pkg::FIRST_W'(first_x[PW-1:0])};
          state <= S_RANGE;
        end
        S_RANGE: begin
          // pages beyond the map are dropped
          if (count == '0 || XW'(start) >= TOTAL) begin
            state <= S_DONE;
          end else begin
            lo     <= start[PW-1:0];
            hi     <= (last_pg >= TOTAL) ? PW'(TOTAL - XW'(1)) : last_pg[PW-1:0];
            iw     <= start[PW-1:cpbm_pkg::BIT_IDX_W];
            iss_on <= 1'b1;
            state  <= S_RMW;
          end
        end
        S_RMW: begin
          if (iss_on) begin
            if (iw == hi[PW-1:cpbm_pkg::BIT_IDX_W]) begin
              iss_on <= 1'b0;
            end else begin
              iw <= iw + WW'(1);
            end
          end
          if (pend && dw == hi[PW-1:cpbm_pkg::BIT_IDX_W]) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          iss_on <= 1'b0;
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
